[rtl/core/apid_pkg.sv]
// Shared types and constants for the actuator position PID block.
// No dependencies; used by every module in rtl/core.
package apid_pkg;

	localparam int DIV_W = 28;
	localparam int DEN_W = 10;
	localparam int CNT_W = 5;
	localparam int POS_W = 12;
	localparam int ERR_W = 13;
	localparam int E8_W  = 23;
	localparam int PRV_W = 21;
	localparam int DIF_W = 24;
	localparam int MA_W  = 23;
	localparam int MB_W  = 16;
	localparam int PRD_W = MA_W + MB_W;
	localparam int TRM_W = 32;
	localparam int ACC_W = 12;
	localparam int CIDX_W = 3;
	localparam int CDAT_W = 16;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_TARGET = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [CIDX_W-1:0] REG_KP    = 3'd0;
	localparam logic [CIDX_W-1:0] REG_KI    = 3'd1;
	localparam logic [CIDX_W-1:0] REG_KD    = 3'd2;
	localparam logic [CIDX_W-1:0] REG_BIAS  = 3'd3;
	localparam logic [CIDX_W-1:0] REG_FBMIN = 3'd4;
	localparam logic [CIDX_W-1:0] REG_FBMAX = 3'd5;
	localparam logic [CIDX_W-1:0] REG_PWMIN = 3'd6;
	localparam logic [CIDX_W-1:0] REG_PWMAX = 3'd7;

	localparam logic [1:0] MUL_I = 2'd0;
	localparam logic [1:0] MUL_P = 2'd1;
	localparam logic [1:0] MUL_D = 2'd2;

	// n*256/100 == n*64/25; floor(m/25) == (m * BIAS_RECIP) >> 32 for m < 2**27
	localparam logic [27:0] BIAS_RECIP = 28'd171798692;

	typedef struct packed {
		logic [15:0] kp;
		logic [15:0] ki;
		logic [15:0] kd;
		logic [7:0]  bias;
		logic [9:0]  fb_min;
		logic [9:0]  fb_max;
		logic [9:0]  pwm_min;
		logic [9:0]  pwm_max;
	} cfg_t;

	typedef struct packed {
		logic       disp;
		logic       ramp;
		logic       div_go;
		logic       take_pos;
		logic       err;
		logic       take_e8;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       take_i;
		logic       take_p;
		logic       take_d;
		logic       finish;
		logic       capture;
	} cmd_t;

	typedef struct packed {
		logic tick;
		logic div_done;
	} stat_t;

endpackage

[rtl/core/actuator_position_pid.sv]
// Position PID controller for a fuel-quantity actuator, with setpoint ramp.
// A control tick runs a divider pass for the feedback mapping plus sequenced scaling
// and multiplies; other requests go straight to the result.
// One request at a time; a result waits in an output register while the next
// request is taken. Reset (arst_n low) restores register defaults, setpoint 42, all
// other controller state 0. Uses apid_pkg/cfg/ctrl/dp/div.
module actuator_position_pid #(
	parameter int SLEW_STEP    = 1,
	parameter int POSITION_MAX = 1023
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [apid_pkg::CIDX_W-1:0] cfg_index,
	input  logic [apid_pkg::CDAT_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [9:0]                  target_position,
	input  logic [9:0]                  feedback_sample,
	input  logic                        skip_drive,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [9:0]                  ramped_setpoint,
	output logic [9:0]                  actuator_position,
	output logic signed [20:0]          p_term,
	output logic [17:0]                 i_term,
	output logic signed [21:0]          d_term,
	output logic [9:0]                  duty,
	output logic                        duty_written,
	output logic [9:0]                  accuracy
);

	apid_pkg::cfg_t  cfg;
	apid_pkg::cmd_t  cmd;
	apid_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	apid_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_idx  (cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	apid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	apid_dp #(
		.SLEW_STEP    (SLEW_STEP),
		.POSITION_MAX (POSITION_MAX)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg          (cfg),
		.in_take      (in_valid && in_ready),
		.in_op        (op),
		.in_target    (target_position),
		.in_sample    (feedback_sample),
		.in_skip      (skip_drive),
		.res_setpoint (ramped_setpoint),
		.res_position (actuator_position),
		.res_p        (p_term),
		.res_i        (i_term),
		.res_d        (d_term),
		.res_duty     (duty),
		.res_written  (duty_written),
		.res_accuracy (accuracy)
	);

endmodule

[rtl/core/apid_cfg.sv]
// Configuration register file for the PID block.
// Depends on apid_pkg.
module apid_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [apid_pkg::CIDX_W-1:0] wr_idx,
	input  logic [apid_pkg::CDAT_W-1:0] wr_data,
	output apid_pkg::cfg_t              cfg
);

	apid_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp      <= 16'd256;
			cfg_q.ki      <= 16'd0;
			cfg_q.kd      <= 16'd0;
			cfg_q.bias    <= 8'd100;
			cfg_q.fb_min  <= 10'd0;
			cfg_q.fb_max  <= 10'd1023;
			cfg_q.pwm_min <= 10'd0;
			cfg_q.pwm_max <= 10'd1023;
		end else if (wr_en) begin
			case (wr_idx)
				apid_pkg::REG_KP:    cfg_q.kp      <= wr_data;
				apid_pkg::REG_KI:    cfg_q.ki      <= wr_data;
				apid_pkg::REG_KD:    cfg_q.kd      <= wr_data;
				apid_pkg::REG_BIAS:  cfg_q.bias    <= wr_data[7:0];
				apid_pkg::REG_FBMIN: cfg_q.fb_min  <= wr_data[9:0];
				apid_pkg::REG_FBMAX: cfg_q.fb_max  <= wr_data[9:0];
				apid_pkg::REG_PWMIN: cfg_q.pwm_min <= wr_data[9:0];
				apid_pkg::REG_PWMAX: cfg_q.pwm_max <= wr_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/apid_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on apid_pkg.
module apid_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [apid_pkg::DIV_W-1:0] dividend,
	input  logic [apid_pkg::DEN_W-1:0] divisor,
	output logic [apid_pkg::DIV_W-1:0] quotient,
	output logic                       done
);

	localparam logic [apid_pkg::CNT_W-1:0] LAST = apid_pkg::CNT_W'(apid_pkg::DIV_W - 1);

	logic                        busy_q;
	logic                        done_q;
	logic [apid_pkg::CNT_W-1:0]  cnt_q;
	logic [apid_pkg::DEN_W-1:0]  rem_q;
	logic [apid_pkg::DEN_W-1:0]  den_q;
	logic [apid_pkg::DIV_W-1:0]  quo_q;
	logic [apid_pkg::DEN_W:0]    trial;
	logic                        ge;

	always_comb begin
		trial = {rem_q, quo_q[apid_pkg::DIV_W-1]};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? apid_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[apid_pkg::DEN_W-1:0];
			quo_q <= {quo_q[apid_pkg::DIV_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

[rtl/core/apid_ctrl.sv]
// Sequencer for the PID block: handshakes and datapath commands.
// Depends on apid_pkg.
module apid_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  apid_pkg::stat_t stat,
	output apid_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_RAMP, S_DIVP, S_ERR, S_BIAS,
		S_MULI, S_MULP, S_MULD, S_TAKED, S_OUT, S_HOLD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_DISP: cmd.disp = 1'b1;
			S_RAMP: begin
				cmd.ramp   = 1'b1;
				cmd.div_go = 1'b1;
			end
			S_DIVP: cmd.take_pos = stat.div_done;
			S_ERR:  cmd.err = 1'b1;
			S_BIAS: cmd.take_e8 = 1'b1;
			S_MULI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = apid_pkg::MUL_I;
			end
			S_MULP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = apid_pkg::MUL_P;
				cmd.take_i  = 1'b1;
			end
			S_MULD: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = apid_pkg::MUL_D;
				cmd.take_p  = 1'b1;
			end
			S_TAKED: cmd.take_d = 1'b1;
			S_OUT:   cmd.finish = 1'b1;
			S_HOLD:  cmd.capture = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_HOLD && slot_free) out_valid_q <= 1'b1;
			else if (out_ready)                 out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_DISP;
				S_DISP:  state_q <= stat.tick ? S_RAMP : S_HOLD;
				S_RAMP:  state_q <= S_DIVP;
				S_DIVP:  if (stat.div_done) state_q <= S_ERR;
				S_ERR:   state_q <= S_BIAS;
				S_BIAS:  state_q <= S_MULI;
				S_MULI:  state_q <= S_MULP;
				S_MULP:  state_q <= S_MULD;
				S_MULD:  state_q <= S_TAKED;
				S_TAKED: state_q <= S_OUT;
				S_OUT:   state_q <= S_HOLD;
				S_HOLD:  if (slot_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

[rtl/core/apid_dp.sv]
// Datapath of the PID block: state registers, mapping, PID math, result registers.
// Depends on apid_pkg and apid_div.
module apid_dp #(
	parameter int SLEW_STEP    = 1,
	parameter int POSITION_MAX = 1023
) (
	input  logic                clk,
	input  logic                arst_n,
	input  apid_pkg::cmd_t      cmd,
	output apid_pkg::stat_t     stat,
	input  apid_pkg::cfg_t      cfg,
	input  logic                in_take,
	input  logic [1:0]          in_op,
	input  logic [9:0]          in_target,
	input  logic [9:0]          in_sample,
	input  logic                in_skip,
	output logic [9:0]          res_setpoint,
	output logic [9:0]          res_position,
	output logic signed [20:0]  res_p,
	output logic [17:0]         res_i,
	output logic signed [21:0]  res_d,
	output logic [9:0]          res_duty,
	output logic                res_written,
	output logic [9:0]          res_accuracy
);

	localparam logic [apid_pkg::POS_W-1:0] PMAX = apid_pkg::POS_W'(POSITION_MAX);
	localparam logic signed [11:0] STEP = 12'(SLEW_STEP);

	// latched request
	logic [1:0] op_q;
	logic [9:0] tgt_in_q, raw_q;
	logic       skip_q;

	// controller state
	logic [9:0]                        sp_q, target_q, duty_reg_q;
	logic [17:0]                       integ_q;
	logic signed [apid_pkg::PRV_W-1:0] prev_q;
	logic [apid_pkg::ACC_W-1:0]        acc_q;

	// per-tick working registers
	logic                              neg_q, zden_q;
	logic [apid_pkg::POS_W-1:0]        pos_q;
	logic signed [apid_pkg::ERR_W-1:0] e_q;
	logic [19:0]                       bprod_q;
	logic signed [apid_pkg::E8_W-1:0]  e8_q;
	logic [apid_pkg::PRD_W-1:0]        prod_q;
	logic signed [20:0]                p_q;
	logic signed [21:0]                d_q;
	logic [9:0]                        duty_q;
	logic                              wr_q;

	// result registers
	logic [9:0]         o_sp_q, o_pos_q, o_duty_q, o_acc_q;
	logic signed [20:0] o_p_q;
	logic [17:0]        o_i_q;
	logic signed [21:0] o_d_q;
	logic               o_wr_q;

	// divider
	logic [apid_pkg::DIV_W-1:0] div_a, quo;
	logic [apid_pkg::DEN_W-1:0] div_b;
	logic                       div_done;

	logic signed [11:0] sp_s, tg_s, up_s, dn_s, sp_nx;
	logic signed [11:0] rdiff;
	logic signed [24:0] num;
	logic [24:0]        num_mag;
	logic signed [10:0] den;
	logic [9:0]         den_mag;
	logic signed [apid_pkg::ERR_W-1:0] e_now;
	logic [11:0]        emag_now;
	logic [19:0]        bias_prod;
	logic [53:0]        bscl;
	logic [apid_pkg::POS_W-1:0] pos_nx;
	logic [21:0]        e8_mag;
	logic signed [apid_pkg::DIF_W-1:0] diff;
	logic [apid_pkg::DIF_W-1:0]        diff_abs;
	logic [apid_pkg::MA_W-1:0]  mul_a;
	logic [apid_pkg::MB_W-1:0]  mul_b;
	logic [30:0]                trm_mag;
	logic                       trm_neg;
	logic signed [apid_pkg::TRM_W-1:0] trm;
	logic signed [33:0] isum, ihi, ilo, iclamp;
	logic signed [24:0] outv, ohi, olo;
	logic [9:0]         duty_nx;
	logic signed [apid_pkg::E8_W-1:0] e8_div;

	always_comb begin
		sp_s = 12'({2'b0, sp_q});
		tg_s = 12'({2'b0, target_q});
		up_s = sp_s + STEP;
		dn_s = sp_s - STEP;
		if (sp_s < tg_s)      sp_nx = (up_s > tg_s) ? tg_s : up_s;
		else if (sp_s > tg_s) sp_nx = (dn_s < tg_s) ? tg_s : dn_s;
		else                  sp_nx = sp_s;

		rdiff   = $signed({2'b0, raw_q}) - $signed({2'b0, cfg.fb_min});
		num     = 25'(rdiff) * $signed({13'b0, PMAX});
		num_mag = num[24] ? 25'(-num) : 25'(num);
		den     = $signed({1'b0, cfg.fb_max}) - $signed({1'b0, cfg.fb_min});
		den_mag = den[10] ? 10'(-den) : 10'(den);

		e_now    = $signed({3'b0, sp_q}) - $signed({1'b0, pos_q});
		emag_now = e_now[apid_pkg::ERR_W-1] ? 12'(-e_now) : 12'(e_now);
		bias_prod = emag_now * cfg.bias;

		div_a = apid_pkg::DIV_W'(num_mag);
		div_b = den_mag;

		if (zden_q || neg_q)                  pos_nx = '0;
		else if (quo > apid_pkg::DIV_W'(PMAX)) pos_nx = PMAX;
		else                                  pos_nx = quo[apid_pkg::POS_W-1:0];

		// |e| * bias * 256 / 100, truncated
		bscl   = {bprod_q, 6'b0} * apid_pkg::BIAS_RECIP;
		e8_div = -$signed({1'b0, bscl[53:32]});

		e8_mag   = e8_q[apid_pkg::E8_W-1] ? 22'(-e8_q) : 22'(e8_q);
		diff     = $signed({e8_q[apid_pkg::E8_W-1], e8_q}) - 24'(prev_q);
		diff_abs = diff[apid_pkg::DIF_W-1] ? 24'(-diff) : 24'(diff);

		case (cmd.mul_sel)
			apid_pkg::MUL_I: begin
				mul_a = {1'b0, e8_mag};
				mul_b = cfg.ki;
			end
			apid_pkg::MUL_P: begin
				mul_a = {1'b0, e8_mag};
				mul_b = cfg.kp;
			end
			apid_pkg::MUL_D: begin
				mul_a = diff_abs[apid_pkg::MA_W-1:0];
				mul_b = cfg.kd;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase

		trm_mag = prod_q[apid_pkg::PRD_W-1:8];
		trm_neg = cmd.take_d ? diff[apid_pkg::DIF_W-1] : e8_q[apid_pkg::E8_W-1];
		trm     = trm_neg ? -$signed({1'b0, trm_mag}) : $signed({1'b0, trm_mag});

		ihi    = $signed({16'b0, cfg.pwm_max, 8'b0});
		ilo    = $signed({16'b0, cfg.pwm_min, 8'b0});
		isum   = $signed({16'b0, integ_q}) + 34'(trm);
		iclamp = (isum > ihi) ? ihi : isum;
		if (iclamp < ilo) iclamp = ilo;

		outv = 25'(p_q) + $signed({7'b0, integ_q}) + 25'(d_q);
		ohi  = $signed({7'b0, cfg.pwm_max, 8'b0});
		olo  = $signed({7'b0, cfg.pwm_min, 8'b0});
		if (outv > ohi)      duty_nx = cfg.pwm_max;
		else if (outv < olo) duty_nx = cfg.pwm_min;
		else                 duty_nx = outv[17:8];
		if (sp_q == 10'd0) duty_nx = '0;
	end

	apid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (div_a),
		.divisor  (div_b),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q       <= 10'd42;
			target_q   <= '0;
			integ_q    <= '0;
			prev_q     <= '0;
			acc_q      <= '0;
			duty_reg_q <= '0;
			op_q       <= apid_pkg::OP_TICK;
		end else begin
			if (in_take) op_q <= in_op;
			if (cmd.disp) begin
				if (op_q == apid_pkg::OP_TARGET) begin
					target_q <= tgt_in_q;
					if (tgt_in_q == 10'd0) sp_q <= '0;
				end else if (op_q == apid_pkg::OP_CLEAR) begin
					integ_q <= '0;
				end
			end
			if (cmd.ramp) sp_q <= sp_nx[9:0];
			if (cmd.err)
				acc_q <= 12'(({1'b0, acc_q} + {1'b0, emag_now}) >> 1);
			if (cmd.take_i) integ_q <= iclamp[17:0];
			if (cmd.finish) begin
				if (e8_q > 23'sd1048575)       prev_q <= 21'sd1048575;
				else if (e8_q < -23'sd1048576) prev_q <= -21'sd1048576;
				else                          prev_q <= e8_q[20:0];
				if (!skip_q) duty_reg_q <= duty_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			tgt_in_q <= in_target;
			raw_q    <= in_sample;
			skip_q   <= in_skip;
		end
		if (cmd.disp) begin
			pos_q  <= '0;
			p_q    <= '0;
			d_q    <= '0;
			wr_q   <= 1'b0;
			duty_q <= duty_reg_q;
		end
		if (cmd.ramp) begin
			neg_q  <= num[24] ^ den[10];
			zden_q <= (den == 11'sd0);
		end
		if (cmd.take_pos) pos_q <= pos_nx;
		if (cmd.err) begin
			e_q     <= e_now;
			bprod_q <= bias_prod;
		end
		if (cmd.take_e8)
			e8_q <= e_q[apid_pkg::ERR_W-1] ? e8_div : $signed({3'b0, e_q[11:0], 8'b0});
		if (cmd.mul_en) prod_q <= mul_a * mul_b;
		if (cmd.take_p) begin
			if (trm > 32'sd1048575)       p_q <= 21'sd1048575;
			else if (trm < -32'sd1048576) p_q <= -21'sd1048576;
			else                          p_q <= trm[20:0];
		end
		if (cmd.take_d) begin
			if (trm > 32'sd2097151)       d_q <= 22'sd2097151;
			else if (trm < -32'sd2097152) d_q <= -22'sd2097152;
			else                          d_q <= trm[21:0];
		end
		if (cmd.finish) begin
			duty_q <= duty_nx;
			wr_q   <= !skip_q;
		end
		if (cmd.capture) begin
			o_sp_q   <= sp_q;
			o_pos_q  <= pos_q[9:0];
			o_p_q    <= p_q;
			o_i_q    <= integ_q;
			o_d_q    <= d_q;
			o_duty_q <= duty_q;
			o_wr_q   <= wr_q;
			o_acc_q  <= acc_q[9:0];
		end
	end

	assign stat.tick     = (op_q == apid_pkg::OP_TICK);
	assign stat.div_done = div_done;

	assign res_setpoint = o_sp_q;
	assign res_position = o_pos_q;
	assign res_p        = o_p_q;
	assign res_i        = o_i_q;
	assign res_d        = o_d_q;
	assign res_duty     = o_duty_q;
	assign res_written  = o_wr_q;
	assign res_accuracy = o_acc_q;

endmodule

[tb/testbench.sv]
// Self-checking bench for actuator_position_pid: a queue-fed request driver, a result
// monitor and a fixed-point PID predictor that tracks setpoint, integrator and history.
// Depends on apid_pkg and the actuator_position_pid RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct {
		logic [1:0] op;
		logic [9:0] tgt;
		logic [9:0] fb;
		logic       skip;
	} pid_req_t;

	typedef struct {
		logic [9:0]  sp;
		logic [9:0]  pos;
		logic [20:0] p;
		logic [17:0] i;
		logic [21:0] d;
		logic [9:0]  duty;
		logic        wr;
		logic [9:0]  acc;
	} pid_res_t;

	logic clk = 0, arst_n = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [apid_pkg::CIDX_W-1:0] cfg_index = '0;
	logic [apid_pkg::CDAT_W-1:0] cfg_data = '0;
	logic in_valid = 0, in_ready;
	logic [1:0] op = '0;
	logic [9:0] target_position = '0, feedback_sample = '0;
	logic skip_drive = 0;
	logic out_valid, out_ready = 0;
	logic [9:0] ramped_setpoint, actuator_position, duty, accuracy;
	logic signed [20:0] p_term;
	logic [17:0] i_term;
	logic signed [21:0] d_term;
	logic duty_written;

	actuator_position_pid dut (.*);

	always #2 clk = ~clk;

	pid_req_t pending_reqs[$];
	pid_res_t expected_res[$];
	int errors = 0;
	int send_idle = 0, recv_stall = 0;
	logic hold_off = 0;
	int phase = 0;

	// predictor state
	apid_pkg::cfg_t shadow_cfg;
	longint sp_q, tgt_q, integ_q, prev_err_q, acc_q, duty_q;

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic pid_res_t predict_pid(pid_req_t r);
		pid_res_t res;
		longint pos, p, d, dt, e, e8, mag, outv, lo, hi, den;
		pos = 0; p = 0; d = 0; dt = duty_q;
		res.wr = 0;
		lo = longint'(shadow_cfg.pwm_min) * 256;
		hi = longint'(shadow_cfg.pwm_max) * 256;
		if (r.op == apid_pkg::OP_TARGET) begin
			tgt_q = r.tgt;
			if (r.tgt == 0)
				sp_q = 0;
		end else if (r.op == apid_pkg::OP_CLEAR) begin
			integ_q = 0;
		end else if (r.op == apid_pkg::OP_TICK) begin
			if (sp_q < tgt_q)
				sp_q = (sp_q + 1 > tgt_q) ? tgt_q : sp_q + 1;
			else if (sp_q > tgt_q)
				sp_q = (sp_q - 1 < tgt_q) ? tgt_q : sp_q - 1;
			den = longint'(shadow_cfg.fb_max) - longint'(shadow_cfg.fb_min);
			if (den != 0)
				pos = (longint'(r.fb) - longint'(shadow_cfg.fb_min)) * 1023 / den;
			pos = clip(pos, 0, 1023);
			e = sp_q - pos;
			mag = e < 0 ? -e : e;
			acc_q = (acc_q + mag) / 2;
			e8 = e * 256;
			if (e < 0)
				e8 = e8 * longint'(shadow_cfg.bias) / 100;
			integ_q += e8 * longint'(shadow_cfg.ki) / 256;
			if (integ_q > hi) integ_q = hi;
			if (integ_q < lo) integ_q = lo;
			p = clip(e8 * longint'(shadow_cfg.kp) / 256, -1048576, 1048575);
			d = clip((e8 - prev_err_q) * longint'(shadow_cfg.kd) / 256,
				-2097152, 2097151);
			prev_err_q = clip(e8, -1048576, 1048575);
			outv = p + integ_q + d;
			if (outv > hi) dt = shadow_cfg.pwm_max;
			else if (outv < lo) dt = shadow_cfg.pwm_min;
			else dt = outv / 256;
			if (sp_q <= 0) dt = 0;
			if (!r.skip) begin
				duty_q = dt;
				res.wr = 1;
			end
		end
		res.sp = sp_q[9:0];
		res.pos = pos[9:0];
		res.p = p[20:0];
		res.i = integ_q[17:0];
		res.d = d[21:0];
		res.duty = dt[9:0];
		res.acc = acc_q[9:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		pid_req_t r;
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && in_ready) begin
				r.op = op; r.tgt = target_position; r.fb = feedback_sample; r.skip = skip_drive;
				expected_res.push_back(predict_pid(r));
			end
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
					r = pending_reqs.pop_front();
					op <= r.op;
					target_position <= r.tgt;
					feedback_sample <= r.fb;
					skip_drive <= r.skip;
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		pid_res_t w;
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_res.size() == 0) begin
					report_mismatch("unexpected result", 0, 0);
				end else begin
					w = expected_res.pop_front();
					if (ramped_setpoint !== w.sp)
						report_mismatch("ramped_setpoint", ramped_setpoint, w.sp);
					if (actuator_position !== w.pos)
						report_mismatch("actuator_position", actuator_position, w.pos);
					if (p_term !== w.p) report_mismatch("p_term", p_term, w.p);
					if (i_term !== w.i) report_mismatch("i_term", i_term, w.i);
					if (d_term !== w.d) report_mismatch("d_term", d_term, w.d);
					if (duty !== w.duty) report_mismatch("duty", duty, w.duty);
					if (duty_written !== w.wr)
						report_mismatch("duty_written", duty_written, w.wr);
					if (accuracy !== w.acc) report_mismatch("accuracy", accuracy, w.acc);
				end
			end
			out_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
		end
	end

	// long receiver hold-off so the block backs up onto its input
	initial begin
		wait (phase == 2);
		@(posedge clk);
		hold_off <= 1;
		repeat (600) @(posedge clk);
		hold_off <= 0;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	task automatic write_reg(logic [apid_pkg::CIDX_W-1:0] idx,
		logic [apid_pkg::CDAT_W-1:0] val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 0;
		case (idx)
			apid_pkg::REG_KP:    shadow_cfg.kp = val;
			apid_pkg::REG_KI:    shadow_cfg.ki = val;
			apid_pkg::REG_KD:    shadow_cfg.kd = val;
			apid_pkg::REG_BIAS:  shadow_cfg.bias = val[7:0];
			apid_pkg::REG_FBMIN: shadow_cfg.fb_min = val[9:0];
			apid_pkg::REG_FBMAX: shadow_cfg.fb_max = val[9:0];
			apid_pkg::REG_PWMIN: shadow_cfg.pwm_min = val[9:0];
			apid_pkg::REG_PWMAX: shadow_cfg.pwm_max = val[9:0];
			default: ;
		endcase
	endtask

	task automatic queue_req(logic [1:0] o, logic [9:0] t, logic [9:0] f, logic s);
		pid_req_t r;
		r.op = o; r.tgt = t; r.fb = f; r.skip = s;
		pending_reqs.push_back(r);
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || in_valid || expected_res.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		int k, n, x;
		shadow_cfg = '{kp: 256, ki: 0, kd: 0, bias: 100, fb_min: 0, fb_max: 1023,
			pwm_min: 0, pwm_max: 1023};
		sp_q = 42; tgt_q = 0; integ_q = 0; prev_err_q = 0; acc_q = 0; duty_q = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: field extremes, every op, zero setpoint, skipped drive
		queue_req(apid_pkg::OP_TICK, 10'd0, 10'd0, 1'b0);
		queue_req(apid_pkg::OP_TICK, 10'd0, 10'd1023, 1'b0);
		queue_req(apid_pkg::OP_TARGET, 10'd1023, 10'd0, 1'b0);
		queue_req(apid_pkg::OP_TICK, 10'd0, 10'd0, 1'b0);
		queue_req(apid_pkg::OP_TICK, 10'd0, 10'd1023, 1'b0);
		queue_req(apid_pkg::OP_TICK, 10'd0, 10'd512, 1'b1);
		queue_req(apid_pkg::OP_CLEAR, 10'd0, 10'd0, 1'b0);
		queue_req(OP_SPARE, 10'd1023, 10'd1023, 1'b1);
		queue_req(apid_pkg::OP_TICK, 10'd1023, 10'd100, 1'b0);
		queue_req(apid_pkg::OP_TARGET, 10'd0, 10'd0, 1'b0);
		queue_req(apid_pkg::OP_TICK, 10'd0, 10'd300, 1'b0);
		queue_req(apid_pkg::OP_TICK, 10'd0, 10'd0, 1'b1);
		queue_req(apid_pkg::OP_TARGET, 10'd1, 10'd0, 1'b0);
		queue_req(apid_pkg::OP_TICK, 10'd0, 10'd0, 1'b0);
		queue_req(apid_pkg::OP_TICK, 10'd0, 10'd1023, 1'b0);
		queue_req(apid_pkg::OP_TARGET, 10'd600, 10'd0, 1'b0);
		queue_req(apid_pkg::OP_TICK, 10'd0, 10'd700, 1'b0);
		drain();

		for (k = 0; k < 8; k++) begin
			case (k)
				0: begin
					write_reg(apid_pkg::REG_KP, 16'hFFFF);
					write_reg(apid_pkg::REG_KI, 16'hFFFF);
					write_reg(apid_pkg::REG_KD, 16'hFFFF);
					write_reg(apid_pkg::REG_BIAS, 16'd255);
					write_reg(apid_pkg::REG_FBMIN, 16'd0);
					write_reg(apid_pkg::REG_FBMAX, 16'd1023);
					write_reg(apid_pkg::REG_PWMIN, 16'd0);
					write_reg(apid_pkg::REG_PWMAX, 16'd1023);
				end
				1: begin
					write_reg(apid_pkg::REG_KP, 16'd0);
					write_reg(apid_pkg::REG_KI, 16'd0);
					write_reg(apid_pkg::REG_KD, 16'd0);
					write_reg(apid_pkg::REG_BIAS, 16'd0);
					write_reg(apid_pkg::REG_FBMIN, 16'd500);
					write_reg(apid_pkg::REG_FBMAX, 16'd500);
					write_reg(apid_pkg::REG_PWMIN, 16'd0);
					write_reg(apid_pkg::REG_PWMAX, 16'd0);
				end
				2: begin
					write_reg(apid_pkg::REG_KP, 16'd400);
					write_reg(apid_pkg::REG_KI, 16'd40);
					write_reg(apid_pkg::REG_KD, 16'd900);
					write_reg(apid_pkg::REG_BIAS, 16'd50);
					write_reg(apid_pkg::REG_FBMIN, 16'd900);
					write_reg(apid_pkg::REG_FBMAX, 16'd100);
					write_reg(apid_pkg::REG_PWMIN, 16'd800);
					write_reg(apid_pkg::REG_PWMAX, 16'd200);
				end
				default: begin
					write_reg(apid_pkg::REG_KP,
						16'($urandom_range(3) == 0 ? $urandom : $urandom_range(2048)));
					write_reg(apid_pkg::REG_KI,
						16'($urandom_range(3) == 0 ? $urandom : $urandom_range(256)));
					write_reg(apid_pkg::REG_KD,
						16'($urandom_range(3) == 0 ? $urandom : $urandom_range(1024)));
					write_reg(apid_pkg::REG_BIAS, 16'($urandom_range(255)));
					write_reg(apid_pkg::REG_FBMIN, 16'($urandom_range(300)));
					write_reg(apid_pkg::REG_FBMAX, 16'($urandom_range(1023, 700)));
					write_reg(apid_pkg::REG_PWMIN, 16'($urandom_range(200)));
					write_reg(apid_pkg::REG_PWMAX, 16'($urandom_range(1023, 500)));
				end
			endcase
			case (k % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 63; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 63; end
				default: begin send_idle = 27; recv_stall = 27; end
			endcase
			for (n = 0; n < 200; n++) begin
				x = $urandom_range(99);
				if (x < 70)
					queue_req(apid_pkg::OP_TICK, 10'($urandom), 10'($urandom),
						$urandom_range(5) == 0);
				else if (x < 86)
					queue_req(apid_pkg::OP_TARGET,
						$urandom_range(7) == 0 ? 10'd0 : 10'($urandom),
						10'($urandom), 1'($urandom));
				else if (x < 94)
					queue_req(apid_pkg::OP_CLEAR, 10'($urandom), 10'($urandom),
						1'($urandom));
				else
					queue_req(OP_SPARE, 10'($urandom), 10'($urandom), 1'($urandom));
			end
			phase = k + 1;
			drain();
		end

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
